FILE: design/tic_line_parser_macros.svh
// assertion macros for the tic line parser
`ifndef TIC_LINE_PARSER_MACROS_SVH
`define TIC_LINE_PARSER_MACROS_SVH

`ifndef SYNTH

`define TIC_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tic assertion failed");

`define TIC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tic assertion failed");

`else

`define TIC_ASSERT_IMPLIES(name, clk, rstn, ante, cons)

`define TIC_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

FILE: design/tic_pkg.sv
// shared types and constants of the tic line parser
`default_nettype none

package tic_pkg;

    localparam int LABEL_CHARS_DEF = 8;
    localparam int QDEPTH          = 2;

    localparam logic [7:0] CH_ETX = 8'd3;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_0   = 8'd48;
    localparam logic [7:0] CH_9   = 8'd57;

    localparam logic [5:0] CHK_BIAS   = 6'd18;
    localparam logic [7:0] CHK_OFFSET = 8'd32;

    localparam logic [3:0] CLS_OTHER  = 4'd0;
    localparam logic [3:0] CLS_EAST   = 4'd1;
    localparam logic [3:0] CLS_EAIT   = 4'd2;
    localparam logic [3:0] CLS_SINSTS = 4'd3;
    localparam logic [3:0] CLS_SINSTI = 4'd4;
    localparam logic [3:0] CLS_DATE   = 4'd5;
    localparam logic [3:0] CLS_URMS1  = 4'd6;
    localparam logic [3:0] CLS_IRMS1  = 4'd7;
    localparam logic [3:0] CLS_STGE   = 4'd8;

    // label prefixes, first character in the low byte
    localparam logic [47:0] PAT_EAST   = {8'h00, 8'h00, "T", "S", "A", "E"};
    localparam logic [47:0] PAT_EAIT   = {8'h00, 8'h00, "T", "I", "A", "E"};
    localparam logic [47:0] PAT_SINSTS = {"S", "T", "S", "N", "I", "S"};
    localparam logic [47:0] PAT_SINSTI = {"I", "T", "S", "N", "I", "S"};
    localparam logic [47:0] PAT_DATE   = {8'h00, 8'h00, "E", "T", "A", "D"};
    localparam logic [47:0] PAT_URMS1  = {8'h00, "1", "S", "M", "R", "U"};
    localparam logic [47:0] PAT_IRMS1  = {8'h00, "1", "S", "M", "R", "I"};
    localparam logic [47:0] PAT_STGE   = {8'h00, 8'h00, "E", "G", "T", "S"};

    typedef enum logic [2:0] {
        K_TEXT,
        K_TAB,
        K_LF,
        K_ETX,
        K_CR
    } tic_kind_t;

    typedef struct packed {
        tic_kind_t  kind;
        logic [7:0] data;
        logic       is_digit;
        logic [3:0] digit;
    } tic_item_t;

    typedef struct packed {
        logic      push;
        tic_item_t item;
    } tic_push_t;

    typedef struct packed {
        logic valid;
        logic full;
    } tic_q_stat_t;

endpackage

`default_nettype wire

FILE: design/tic_front.sv
// front end: accepts received bytes and classifies them for the queue
`default_nettype none

module tic_front (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire tic_pkg::tic_q_stat_t q_stat,
    output tic_pkg::tic_push_t      q_push
);

    tic_pkg::tic_kind_t kind;
    logic [7:0]         digit_full;

    always_comb begin
        case (s_rx_byte)
            tic_pkg::CH_TAB: kind = tic_pkg::K_TAB;
            tic_pkg::CH_LF:  kind = tic_pkg::K_LF;
            tic_pkg::CH_ETX: kind = tic_pkg::K_ETX;
            tic_pkg::CH_CR:  kind = tic_pkg::K_CR;
            default:         kind = tic_pkg::K_TEXT;
        endcase
    end

    assign digit_full = s_rx_byte - tic_pkg::CH_0;
    assign s_ready    = !q_stat.full;

    always_comb begin
        q_push.push          = s_valid && s_ready;
        q_push.item.kind     = kind;
        q_push.item.data     = s_rx_byte;
        q_push.item.is_digit = (s_rx_byte >= tic_pkg::CH_0) && (s_rx_byte <= tic_pkg::CH_9);
        q_push.item.digit    = digit_full[3:0];
    end

endmodule

`default_nettype wire

FILE: design/tic_queue.sv
// short queue of classified bytes between front and back
`default_nettype none

module tic_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tic_pkg::tic_push_t   q_push,
    input  wire logic                 q_pop,
    output tic_pkg::tic_item_t        q_item,
    output tic_pkg::tic_q_stat_t      q_stat
);

    localparam int PTR_W = (tic_pkg::QDEPTH > 1) ? $clog2(tic_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(tic_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tic_pkg::QDEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tic_pkg::QDEPTH - 1);

    tic_pkg::tic_item_t slot_reg [tic_pkg::QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !q_push.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            slot_reg[wr_ptr_reg] <= q_push.item;
        end
    end

    assign q_item       = slot_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == CNT_FULL);

endmodule

`default_nettype wire

FILE: design/tic_back.sv
// back end: line state, checksum, value decoding and result register
`default_nettype none

module tic_back #(
    parameter int LABEL_CHARS = tic_pkg::LABEL_CHARS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tic_pkg::tic_q_stat_t q_stat,
    input  wire tic_pkg::tic_item_t   q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [3:0]                m_label_class,
    output logic [31:0]               m_value_number,
    output logic [7:0]                m_value_second_char,
    output logic                      m_checksum_present,
    output logic                      m_checksum_ok
);

    localparam int IDX_W = $clog2(LABEL_CHARS);
    localparam logic [4:0] LBL_LIMIT = 5'(LABEL_CHARS);

    logic       line_open_reg, line_open_next;
    logic [1:0] tab_count_reg, tab_count_next;
    logic [5:0] sum_reg, sum_next;
    logic [7:0] label_text_reg [LABEL_CHARS];
    logic [3:0] label_length_reg, label_length_next;
    logic [31:0] number_reg, number_next;
    logic [3:0] value_length_reg, value_length_next;
    logic       digits_ended_reg, digits_ended_next;
    logic [7:0] second_char_reg, second_char_next;
    logic [7:0] check_reg, check_next;
    logic       check_captured_reg, check_captured_next;

    logic        m_valid_reg, m_valid_next;
    logic [3:0]  class_reg;
    logic [31:0] number_out_reg;
    logic [7:0]  second_out_reg;
    logic        present_reg;
    logic        ok_reg;

    logic        is_cr, is_text, take;
    logic        out_stalled, out_load, label_we;
    logic [35:0] number_times_ten;
    logic [47:0] label_head;
    logic [3:0]  class_now;
    logic [7:0]  expect_check;

    function automatic logic pfx(input logic [47:0] txt, input logic [47:0] pat,
                                 input logic [2:0] n, input logic [3:0] len);
        logic ok;
        ok = (len >= {1'b0, n});
        for (int i = 0; i < 6; i++) begin
            if ((3'(i) < n) && (txt[8*i +: 8] != pat[8*i +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign label_head = {label_text_reg[5], label_text_reg[4], label_text_reg[3],
                         label_text_reg[2], label_text_reg[1], label_text_reg[0]};

    always_comb begin
        if (pfx(label_head, tic_pkg::PAT_EAST, 3'd4, label_length_reg)) begin
            class_now = tic_pkg::CLS_EAST;
        end else if (pfx(label_head, tic_pkg::PAT_EAIT, 3'd4, label_length_reg)) begin
            class_now = tic_pkg::CLS_EAIT;
        end else if (label_length_reg == 4'd6 &&
                     pfx(label_head, tic_pkg::PAT_SINSTS, 3'd6, label_length_reg)) begin
            class_now = tic_pkg::CLS_SINSTS;
        end else if (pfx(label_head, tic_pkg::PAT_SINSTI, 3'd6, label_length_reg)) begin
            class_now = tic_pkg::CLS_SINSTI;
        end else if (pfx(label_head, tic_pkg::PAT_DATE, 3'd4, label_length_reg)) begin
            class_now = tic_pkg::CLS_DATE;
        end else if (pfx(label_head, tic_pkg::PAT_URMS1, 3'd5, label_length_reg)) begin
            class_now = tic_pkg::CLS_URMS1;
        end else if (pfx(label_head, tic_pkg::PAT_IRMS1, 3'd5, label_length_reg)) begin
            class_now = tic_pkg::CLS_IRMS1;
        end else if (pfx(label_head, tic_pkg::PAT_STGE, 3'd4, label_length_reg)) begin
            class_now = tic_pkg::CLS_STGE;
        end else begin
            class_now = tic_pkg::CLS_OTHER;
        end
    end

    // 6-bit add wraps, which is the mask
    assign expect_check = {2'b00, sum_reg + tic_pkg::CHK_BIAS} + tic_pkg::CHK_OFFSET;

    assign is_cr       = (q_item.kind == tic_pkg::K_CR);
    assign out_stalled = m_valid_reg && !m_ready;
    // a closing cr needs the result register free
    assign q_pop       = q_stat.valid && !(is_cr && line_open_reg && out_stalled);
    assign out_load    = q_pop && is_cr && line_open_reg;
    assign is_text     = (q_item.kind == tic_pkg::K_TEXT) || (q_item.kind == tic_pkg::K_TAB);
    assign take        = q_pop && is_text && line_open_reg;
    assign label_we    = take && (q_item.kind == tic_pkg::K_TEXT) && (tab_count_reg == 2'd0) &&
                         ({1'b0, label_length_reg} < LBL_LIMIT);

    assign number_times_ten = {1'b0, number_reg, 3'b000} + {3'b000, number_reg, 1'b0} +
                              {32'd0, q_item.digit};

    always_comb begin
        line_open_next      = line_open_reg;
        tab_count_next      = tab_count_reg;
        sum_next            = sum_reg;
        label_length_next   = label_length_reg;
        number_next         = number_reg;
        value_length_next   = value_length_reg;
        digits_ended_next   = digits_ended_reg;
        second_char_next    = second_char_reg;
        check_next          = check_reg;
        check_captured_next = check_captured_reg;
        if (q_pop) begin
            case (q_item.kind)
                tic_pkg::K_LF: begin
                    line_open_next      = 1'b1;
                    tab_count_next      = 2'd0;
                    sum_next            = '0;
                    label_length_next   = '0;
                    number_next         = '0;
                    value_length_next   = '0;
                    digits_ended_next   = 1'b0;
                    second_char_next    = '0;
                    check_next          = '0;
                    check_captured_next = 1'b0;
                end
                tic_pkg::K_ETX: begin
                    line_open_next = 1'b0;
                end
                tic_pkg::K_CR: begin
                    line_open_next = 1'b0;
                end
                default: begin
                    if (take) begin
                        if (tab_count_reg == 2'd2 && !check_captured_reg) begin
                            check_next          = q_item.data;
                            check_captured_next = 1'b1;
                        end
                        if (q_item.kind == tic_pkg::K_TAB) begin
                            if (tab_count_reg != 2'd3) begin
                                tab_count_next = tab_count_reg + 1'b1;
                            end
                        end else begin
                            if (tab_count_reg == 2'd0) begin
                                if (label_length_reg != 4'd15) begin
                                    label_length_next = label_length_reg + 1'b1;
                                end
                            end else if (tab_count_reg == 2'd1) begin
                                if (value_length_reg == 4'd1) begin
                                    second_char_next = q_item.data;
                                end
                                if (value_length_reg != 4'd15) begin
                                    value_length_next = value_length_reg + 1'b1;
                                end
                                if (!digits_ended_reg) begin
                                    if (q_item.is_digit) begin
                                        number_next = (number_times_ten[35:32] != 4'd0) ?
                                                      32'hFFFF_FFFF : number_times_ten[31:0];
                                    end else begin
                                        digits_ended_next = 1'b1;
                                    end
                                end
                            end
                            if (tab_count_reg[1] == 1'b0) begin
                                sum_next = sum_reg + q_item.data[5:0];
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_open_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            line_open_reg <= line_open_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // line registers other than the label text are cleared by the opening lf before use
    always_ff @(posedge aclk) begin
        tab_count_reg      <= tab_count_next;
        sum_reg            <= sum_next;
        label_length_reg   <= label_length_next;
        number_reg         <= number_next;
        value_length_reg   <= value_length_next;
        digits_ended_reg   <= digits_ended_next;
        second_char_reg    <= second_char_next;
        check_reg          <= check_next;
        check_captured_reg <= check_captured_next;
        if (label_we) begin
            label_text_reg[label_length_reg[IDX_W-1:0]] <= q_item.data;
        end
        if (out_load) begin
            class_reg      <= class_now;
            number_out_reg <= number_reg;
            second_out_reg <= (value_length_reg >= 4'd2) ? second_char_reg : 8'd0;
            present_reg    <= check_captured_reg;
            ok_reg         <= check_captured_reg && (check_reg == expect_check);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_label_class       = class_reg;
    assign m_value_number      = number_out_reg;
    assign m_value_second_char = second_out_reg;
    assign m_checksum_present  = present_reg;
    assign m_checksum_ok       = ok_reg;

endmodule

`default_nettype wire

FILE: design/tic_line_parser.sv
// top level of the tic line parser: front, queue and back
//
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_rx_byte (8)
// m_        out  m_valid/m_ready    class (4), number (32), second char (8), present, ok
//
// one byte per cycle sustained while results are taken, the back end then retiring one queued byte each cycle.
// a result appears in the cycle after its cr leaves the queue and sits in an output register.
// s_ready drops only when the two-entry queue is full; a cr stalls in the queue
// while the previous result is still unread.
// reset is synchronous, active low, and closes any open line.
`default_nettype none

`include "tic_line_parser_macros.svh"

module tic_line_parser #(
    parameter int LABEL_CHARS = tic_pkg::LABEL_CHARS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_label_class,
    output logic [31:0]      m_value_number,
    output logic [7:0]       m_value_second_char,
    output logic             m_checksum_present,
    output logic             m_checksum_ok
);

    tic_pkg::tic_push_t   q_push;
    tic_pkg::tic_item_t   q_item;
    tic_pkg::tic_q_stat_t q_stat;
    logic                 q_pop;
    logic                 cr_popped;

    tic_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    tic_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .q_stat  (q_stat)
    );

    tic_back #(
        .LABEL_CHARS (LABEL_CHARS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_stat              (q_stat),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_label_class       (m_label_class),
        .m_value_number      (m_value_number),
        .m_value_second_char (m_value_second_char),
        .m_checksum_present  (m_checksum_present),
        .m_checksum_ok       (m_checksum_ok)
    );

    assign cr_popped = q_pop && (q_item.kind == tic_pkg::K_CR);

    // an accepted byte is in the queue on the next cycle
    `TIC_ASSERT_NEXT(a_push_lands, aclk, aresetn, s_valid && s_ready, q_stat.valid)
    // a new result only comes from a cr leaving the queue
    `TIC_ASSERT_IMPLIES(a_result_from_cr, aclk, aresetn, $rose(m_valid), $past(cr_popped))
    // never pop while the queue is empty
    `TIC_ASSERT_IMPLIES(a_pop_has_item, aclk, aresetn, q_pop, q_stat.valid)

endmodule

`default_nettype wire
